// ===== src/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types, codes and the microprogram of the iterative integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int FIELD_W = 32;
    localparam int OP_W    = 3;
    localparam int UPC_W   = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_FACT = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_FACT_OVF = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [FIELD_W-1:0] operand_a;
        logic signed [FIELD_W-1:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] result;
        logic [1:0]                status;
    } out_item_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_ADD,
        DP_SUB,
        DP_MUL_STEP,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_FIX,
        DP_FACT_INIT,
        DP_FACT_STEP
    } dp_op_t;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_CNT_MORE,
        JC_A_NEG,
        JC_B_ZERO,
        JC_FACT_MORE
    } jump_cond_t;

    typedef struct packed {
        dp_op_t           dp_op;
        jump_cond_t       cond;
        logic [UPC_W-1:0] target;
        logic             fin;
    } ucode_word_t;

    // sequencer to datapath
    typedef struct packed {
        logic   load;
        logic   exec;
        dp_op_t dp_op;
    } dp_ctl_t;

    // datapath to sequencer
    typedef struct packed {
        logic cnt_more;
        logic a_neg;
        logic b_zero;
        logic fact_more;
    } dp_flags_t;

    // microprogram addresses
    localparam logic [UPC_W-1:0] UPC_ADD       = 4'd0;
    localparam logic [UPC_W-1:0] UPC_SUB       = 4'd1;
    localparam logic [UPC_W-1:0] UPC_DIV       = 4'd2;
    localparam logic [UPC_W-1:0] UPC_DIV_STEP  = 4'd3;
    localparam logic [UPC_W-1:0] UPC_DIV_FIX   = 4'd4;
    localparam logic [UPC_W-1:0] UPC_FACT      = 4'd5;
    localparam logic [UPC_W-1:0] UPC_FACT_STEP = 4'd6;
    localparam logic [UPC_W-1:0] UPC_FIN       = 4'd7;
    localparam logic [UPC_W-1:0] UPC_MUL       = 4'd8;
    localparam logic [UPC_W-1:0] UPC_MUL_FIN   = 4'd9;

    function automatic ucode_word_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_word_t w;
        unique case (addr)
            UPC_ADD:       w = '{DP_ADD,       JC_ALWAYS,    UPC_FIN,       1'b0};
            UPC_SUB:       w = '{DP_SUB,       JC_ALWAYS,    UPC_FIN,       1'b0};
            UPC_DIV:       w = '{DP_DIV_INIT,  JC_B_ZERO,    UPC_FIN,       1'b0};
            UPC_DIV_STEP:  w = '{DP_DIV_STEP,  JC_CNT_MORE,  UPC_DIV_STEP,  1'b0};
            UPC_DIV_FIX:   w = '{DP_DIV_FIX,   JC_ALWAYS,    UPC_FIN,       1'b0};
            UPC_FACT:      w = '{DP_FACT_INIT, JC_A_NEG,     UPC_FIN,       1'b0};
            UPC_FACT_STEP: w = '{DP_FACT_STEP, JC_FACT_MORE, UPC_FACT_STEP, 1'b0};
            UPC_FIN:       w = '{DP_NOP,       JC_NEVER,     UPC_FIN,       1'b1};
            UPC_MUL:       w = '{DP_MUL_STEP,  JC_CNT_MORE,  UPC_MUL,       1'b0};
            UPC_MUL_FIN:   w = '{DP_NOP,       JC_NEVER,     UPC_FIN,       1'b1};
            default:       w = '{DP_NOP,       JC_NEVER,     UPC_FIN,       1'b1};
        endcase
        return w;
    endfunction

    // entry point of each operation; unknown codes go straight to finish
    function automatic logic [UPC_W-1:0] ucode_entry(input logic [OP_W-1:0] op);
        logic [UPC_W-1:0] a;
        unique case (op)
            OP_ADD:  a = UPC_ADD;
            OP_SUB:  a = UPC_SUB;
            OP_MUL:  a = UPC_MUL;
            OP_FACT: a = UPC_FACT;
            OP_DIV:  a = UPC_DIV;
            default: a = UPC_FIN;
        endcase
        return a;
    endfunction

endpackage

// ===== src/ialu_datapath.sv =====
// ----------------------------------------------------------------------------
// ialu_datapath
// Registers, adder, shift-add multiply, restoring divide and factorial step,
// each action selected by the current control word.
// ----------------------------------------------------------------------------
module ialu_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    aclk,
    input  ialu_pkg::dp_ctl_t       ctl,
    input  logic [DATA_WIDTH-1:0]   ld_a,
    input  logic [DATA_WIDTH-1:0]   ld_b,
    output ialu_pkg::dp_flags_t     flags,
    output logic [DATA_WIDTH-1:0]   result,
    output logic [1:0]              status
);

    localparam int DW    = DATA_WIDTH;
    // factorial index runs past DW before the product clears, stays under 2*DW
    localparam int CNT_W = $clog2(4 * DATA_WIDTH);
    localparam int PW    = DW + CNT_W + 1;

    logic [DW-1:0]    acc_reg, acc_next;
    logic [DW-1:0]    a_reg, a_next;
    logic [DW-1:0]    b_reg, b_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [1:0]       status_reg, status_next;

    logic signed [PW-1:0] prod;
    logic                 prod_ovf;
    logic [DW:0]          shifted;
    logic [DW:0]          diff;
    logic                 qbit;

    function automatic logic [DW-1:0] magnitude(input logic [DW-1:0] v);
        return v[DW-1] ? (DW'(0) - v) : v;
    endfunction

    assign prod     = PW'($signed(acc_reg)) * PW'($signed({1'b0, cnt_reg}));
    assign prod_ovf = !((&prod[PW-1:DW-1]) || !(|prod[PW-1:DW-1]));
    assign shifted  = {rem_reg, a_reg[DW-1]};
    assign diff     = shifted - {1'b0, b_reg};
    assign qbit     = !diff[DW];

    assign flags.cnt_more  = cnt_reg != CNT_W'(DW - 1);
    assign flags.a_neg     = a_reg[DW-1];
    assign flags.b_zero    = b_reg == '0;
    assign flags.fact_more = (DW'(cnt_reg) <= a_reg) && (acc_reg != '0);

    always_comb begin
        acc_next    = acc_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        status_next = status_reg;
        if (ctl.load) begin
            acc_next    = '0;
            a_next      = ld_a;
            b_next      = ld_b;
            rem_next    = '0;
            cnt_next    = '0;
            neg_next    = 1'b0;
            status_next = ialu_pkg::ST_OK;
        end else if (ctl.exec) begin
            unique case (ctl.dp_op)
                ialu_pkg::DP_ADD: acc_next = a_reg + b_reg;
                ialu_pkg::DP_SUB: acc_next = a_reg - b_reg;
                ialu_pkg::DP_MUL_STEP: begin
                    if (b_reg[0]) begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next   = {a_reg[DW-2:0], 1'b0};
                    b_next   = {1'b0, b_reg[DW-1:1]};
                    cnt_next = cnt_reg + 1'b1;
                end
                ialu_pkg::DP_DIV_INIT: begin
                    if (b_reg == '0) begin
                        status_next = ialu_pkg::ST_DIV_ZERO;
                    end else begin
                        a_next   = magnitude(a_reg);
                        b_next   = magnitude(b_reg);
                        neg_next = a_reg[DW-1] ^ b_reg[DW-1];
                    end
                end
                ialu_pkg::DP_DIV_STEP: begin
                    rem_next = qbit ? diff[DW-1:0] : shifted[DW-1:0];
                    a_next   = {a_reg[DW-2:0], qbit};
                    cnt_next = cnt_reg + 1'b1;
                end
                ialu_pkg::DP_DIV_FIX: acc_next = neg_reg ? (DW'(0) - a_reg) : a_reg;
                ialu_pkg::DP_FACT_INIT: begin
                    if (a_reg[DW-1]) begin
                        status_next = ialu_pkg::ST_FACT_OVF;
                    end else begin
                        acc_next = DW'(1);
                        cnt_next = CNT_W'(2);
                    end
                end
                ialu_pkg::DP_FACT_STEP: begin
                    if (flags.fact_more) begin
                        acc_next = prod[DW-1:0];
                        cnt_next = cnt_reg + 1'b1;
                        if (prod_ovf) begin
                            status_next = ialu_pkg::ST_FACT_OVF;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        status_reg <= status_next;
    end

    assign result = acc_reg;
    assign status = status_reg;

endmodule

// ===== src/ialu_sequencer.sv =====
// ----------------------------------------------------------------------------
// ialu_sequencer
// Microprogram counter with conditional jumps, input handshake and finish.
// ----------------------------------------------------------------------------
module ialu_sequencer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic [ialu_pkg::OP_W-1:0]    in_op,
    output logic                         in_ready,
    input  logic                         slot_free,
    input  ialu_pkg::dp_flags_t          flags,
    output ialu_pkg::dp_ctl_t            ctl,
    output logic                         done
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                      state_reg, state_next;
    logic [ialu_pkg::UPC_W-1:0]  pc_reg, pc_next;
    ialu_pkg::ucode_word_t       word;
    logic                        cond_true;
    logic                        accept;
    logic                        running;

    assign word    = ialu_pkg::ucode_rom(pc_reg);
    assign running = state_reg == S_RUN;
    assign in_ready = state_reg == S_IDLE;
    assign accept  = in_valid && in_ready;

    always_comb begin
        unique case (word.cond)
            ialu_pkg::JC_NEVER:     cond_true = 1'b0;
            ialu_pkg::JC_ALWAYS:    cond_true = 1'b1;
            ialu_pkg::JC_CNT_MORE:  cond_true = flags.cnt_more;
            ialu_pkg::JC_A_NEG:     cond_true = flags.a_neg;
            ialu_pkg::JC_B_ZERO:    cond_true = flags.b_zero;
            ialu_pkg::JC_FACT_MORE: cond_true = flags.fact_more;
            default:                cond_true = 1'b0;
        endcase
    end

    assign ctl.load  = accept;
    assign ctl.exec  = running && !word.fin;
    assign ctl.dp_op = word.dp_op;
    assign done      = running && word.fin && slot_free;

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_RUN;
                    pc_next    = ialu_pkg::ucode_entry(in_op);
                end
            end
            S_RUN: begin
                if (word.fin) begin
                    // hold on the finish word until the output slot opens
                    if (slot_free) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    pc_next = cond_true ? word.target : pc_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pc_reg    <= ialu_pkg::UPC_FIN;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_enters_program: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_RUN) && (pc_reg == ialu_pkg::ucode_entry($past(in_op))))
        else $error("accepted transaction did not start at its entry point");

    a_done_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> slot_free)
        else $error("result finished into a full output slot");

    a_finish_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (running && word.fin && slot_free) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after finish");
`endif

endmodule

// ===== src/iterative_integer_alu_core.sv =====
// ----------------------------------------------------------------------------
// iterative_integer_alu_core
// Signed integer unit: add, subtract, multiply, factorial and divide.
// ----------------------------------------------------------------------------
// One transaction at a time runs through a small microprogram. Multiply
// runs one shift-add step a cycle over the DATA_WIDTH multiplier bits;
// divide runs one restoring step a cycle over DATA_WIDTH bits, plus sign fix,
// and ends at once on a zero divisor; factorial multiplies in one index a
// step up to the argument n, ends at once on a negative argument, and stops
// early once the wrapped product reaches zero. Unknown operations go straight
// to finish. The sequencer runs one microcode step per cycle and holds on the
// finish word while the output slot is full. The result sits in an output
// register, and the input is ready again in the same cycle that the result
// appears there, whether or not it has been taken.
module iterative_integer_alu_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ialu_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ialu_pkg::out_item_t  m_data
);

    logic [DATA_WIDTH-1:0]  ld_a;
    logic [DATA_WIDTH-1:0]  ld_b;
    logic [DATA_WIDTH-1:0]  dp_result;
    logic [1:0]             dp_status;
    ialu_pkg::dp_ctl_t      ctl;
    ialu_pkg::dp_flags_t    flags;
    logic                   done;
    logic                   slot_free;

    logic                   m_valid_reg;
    ialu_pkg::out_item_t    m_data_reg;

    // operands sign-extend or truncate to the internal width
    assign ld_a = DATA_WIDTH'(s_data.operand_a);
    assign ld_b = DATA_WIDTH'(s_data.operand_b);

    assign slot_free = !m_valid_reg || m_ready;

    ialu_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_op     (s_data.operation),
        .in_ready  (s_ready),
        .slot_free (slot_free),
        .flags     (flags),
        .ctl       (ctl),
        .done      (done)
    );

    ialu_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk   (aclk),
        .ctl    (ctl),
        .ld_a   (ld_a),
        .ld_b   (ld_b),
        .flags  (flags),
        .result (dp_result),
        .status (dp_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg.result <= ialu_pkg::FIELD_W'(dp_result);
            m_data_reg.status <= dp_status;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_slot_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && !done) |=> !m_valid_reg)
        else $error("output slot kept a transaction that was taken");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after an accepted transaction");
`endif

endmodule
